/* design/abt_pkg.sv */
// Shared types, codes and constants of the two-dimensional alpha-beta tracker.
package abt_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam logic [15:0] MAX_STEPS_RST = 16'd16;

  localparam logic [1:0] CMD_INIT = 2'd0;
  localparam logic [1:0] CMD_MEAS = 2'd1;
  localparam logic [1:0] CMD_PRED = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_INIT = 2'd1;
  localparam logic [1:0] ST_ZERO_DT = 2'd2;

  localparam logic [1:0] DS_VX = 2'd0;
  localparam logic [1:0] DS_VY = 2'd1;
  localparam logic [1:0] DS_GA = 2'd2;
  localparam logic [1:0] DS_GB = 2'd3;

  typedef struct packed {
    logic       latch;
    logic       decode;
    logic       mul1;
    logic       mul2;
    logic       extrap;
    logic       step_inc;
    logic       blend1;
    logic       blend2;
    logic       finish;
    logic       div_start;
    logic       div_take;
    logic [1:0] div_sel;
  } ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       fin;
    logic       rdy;
    logic       dt_zero;
    logic       step_lt;
    logic       div_done;
  } sts_t;

endpackage

/* design/alpha_beta_track_filter_2d_top.sv */
// Top level of the two-dimensional alpha-beta tracker with growing-memory gains.
//
//   Channel  Handshake                  Payload
//   in       in_valid_i / in_ready_o    command, coord_x, coord_y, stamp, final_point
//   out      out_valid_o / out_ready_i  pos_x, pos_y, pos_time, vel_x, vel_y, status
//   cfg      cfg_we_i                   cfg_wdata_i (max_steps)
//
// One transaction is processed at a time. Each division runs on the shared bit-serial
// divider; a measurement uses two of them for the velocity unless its interval is zero,
// and two more when the gains are recomputed, and a final init point uses up to four.
// Reset clears the track to the not initialised state with max_steps at 16. A finished
// result waits in the output register while the next transaction is accepted; a stalled
// output holds the block only at its end.
module alpha_beta_track_filter_2d_top #(
  parameter int unsigned FRAC_BITS = abt_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         command_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic [31:0]        stamp_i,
  input  logic               final_point_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic [31:0]        pos_time_o,
  output logic signed [47:0] vel_x_o,
  output logic signed [47:0] vel_y_o,
  output logic [1:0]         status_o,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i
);

  abt_pkg::ctl_t ctl;
  abt_pkg::sts_t sts;

  abt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  abt_dp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .command_i    (command_i),
    .coord_x_i    (coord_x_i),
    .coord_y_i    (coord_y_i),
    .stamp_i      (stamp_i),
    .final_point_i(final_point_i),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .pos_time_o   (pos_time_o),
    .vel_x_o      (vel_x_o),
    .vel_y_o      (vel_y_o),
    .status_o     (status_o)
  );

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.finish |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten while still held");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second transaction accepted while one is in progress");

  a_div_not_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.div_start |=> !sts.div_done)
    else $error("divider reported completion straight after start");

  a_single_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl.latch, ctl.decode, ctl.mul1, ctl.mul2, ctl.extrap,
              ctl.blend1, ctl.blend2, ctl.finish, ctl.div_start, ctl.div_take}))
    else $error("more than one datapath step commanded in a cycle");

endmodule

/* design/abt_div.sv */
// Restoring unsigned divider producing one quotient bit per cycle.
module abt_div #(
  parameter int unsigned DVW = 51,
  parameter int unsigned DSW = 33
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [DVW-1:0] dividend_i,
  input  logic [DSW-1:0] divisor_i,
  output logic [DVW-1:0] quotient_o,
  output logic           done_o
);

  localparam int unsigned CW = $clog2(DVW + 1);

  logic [CW-1:0]  cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [DSW-1:0] rem_q, rem_d;
  logic [DSW-1:0] dsr_q;
  logic [DVW-1:0] quo_q, quo_d;
  logic [DSW:0]   shifted;
  logic [DSW+1:0] diff;

  assign shifted = {rem_q, quo_q[DVW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DVW);
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      if (diff[DSW+1]) begin
        rem_d = shifted[DSW-1:0];
        quo_d = {quo_q[DVW-2:0], 1'b0};
      end else begin
        rem_d = diff[DSW-1:0];
        quo_d = {quo_q[DVW-2:0], 1'b1};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dsr_q <= divisor_i;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

/* design/abt_dp.sv */
// Datapath of the tracker: state registers, multipliers, shared divider and result register.
module abt_dp #(
  parameter int unsigned FRAC_BITS = abt_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  abt_pkg::ctl_t       ctl_i,
  output abt_pkg::sts_t       sts_o,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic [1:0]          command_i,
  input  logic signed [31:0]  coord_x_i,
  input  logic signed [31:0]  coord_y_i,
  input  logic [31:0]         stamp_i,
  input  logic                final_point_i,
  output logic signed [31:0]  pos_x_o,
  output logic signed [31:0]  pos_y_o,
  output logic [31:0]         pos_time_o,
  output logic signed [47:0]  vel_x_o,
  output logic signed [47:0]  vel_y_o,
  output logic [1:0]          status_o
);

  localparam int unsigned GW  = FRAC_BITS + 2;
  localparam int unsigned DVW = FRAC_BITS + 35;
  localparam int unsigned DSW = 33;
  localparam int unsigned SH  = 2 * FRAC_BITS;
  localparam logic [40:0] CAP = 41'h100_0000_0000;

  function automatic logic signed [31:0] sat_pos(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat_vel(input logic signed [63:0] v);
    if (v > 64'sh0000_7FFF_FFFF_FFFF) begin
      return 48'sh7FFF_FFFF_FFFF;
    end else if (v < -64'sh0000_8000_0000_0000) begin
      return 48'sh8000_0000_0000;
    end
    return v[47:0];
  endfunction

  logic [1:0]         cmd_q;
  logic signed [31:0] in_x_q, in_y_q;
  logic [31:0]        in_t_q;
  logic               fin_q;
  logic signed [31:0] first_x_q, first_y_q;
  logic [31:0]        first_t_q;
  logic [15:0]        pc_q, pc_d;
  logic signed [31:0] trk_x_q, trk_y_q;
  logic [31:0]        trk_t_q;
  logic signed [47:0] spd_x_q, spd_y_q, spd_x_d, spd_y_d;
  logic [15:0]        step_q;
  logic [GW-1:0]      alpha_q, beta_q;
  logic               rdy_q;
  logic [15:0]        max_q;
  logic signed [32:0] dt_q, dt_d;
  logic [56:0]        ph_x_q, ph_y_q;
  logic [80:0]        pp_x_q, pp_y_q;
  logic signed [31:0] ex_q, ey_q, ex_d, ey_d;
  logic signed [32:0] rx_q, ry_q, rx_d, ry_d;
  logic [DVW-1:0]     pa_x_q, pa_y_q, pb_x_q, pb_y_q;
  logic signed [31:0] ox_q, oy_q, ox_d, oy_d;

  logic signed [31:0] res_x_q, res_y_q, res_x_d, res_y_d;
  logic [31:0]        res_t_q, res_t_d;
  logic signed [47:0] res_vx_q, res_vy_q;
  logic [1:0]         res_st_q, res_st_d;

  logic               is_init;
  logic [31:0]        first_t_eff, base_t;
  logic [32:0]        dt_mag;
  logic [47:0]        spd_mx, spd_my;
  logic [56:0]        lo_x, lo_y;
  logic [80:0]        sh_x, sh_y;
  logic [40:0]        r_x, r_y;
  logic signed [63:0] off_x, off_y;
  logic signed [32:0] mx, my;
  logic [32:0]        rx_mag, ry_mag;
  logic [63:0]        ad_x, ad_y;
  logic signed [32:0] dx_x, dx_y;
  logic [32:0]        dx_mx, dx_my;
  logic [16:0]        n17;
  logic [17:0]        n18;
  logic [33:0]        den_full;
  logic [32:0]        den;
  logic [18:0]        a_coef;
  logic [DVW-1:0]     div_num;
  logic [DSW-1:0]     div_dsr;
  logic [DVW-1:0]     quo;
  logic               div_done;
  logic [63:0]        q64;
  logic               neg_vx, neg_vy;
  logic signed [63:0] base_vx, base_vy;

  assign is_init = (cmd_q == abt_pkg::CMD_INIT);

  assign pc_d        = (pc_q == 16'hFFFF) ? pc_q : pc_q + 16'd1;
  assign first_t_eff = (pc_q == 16'd0) ? in_t_q : first_t_q;
  assign base_t      = is_init ? first_t_eff : trk_t_q;
  assign dt_d        = $signed({1'b0, in_t_q}) - $signed({1'b0, base_t});
  assign dt_mag      = dt_q[32] ? 33'(-dt_q) : 33'(dt_q);

  assign spd_mx = spd_x_q[47] ? 48'(-spd_x_q) : 48'(spd_x_q);
  assign spd_my = spd_y_q[47] ? 48'(-spd_y_q) : 48'(spd_y_q);
  assign lo_x   = spd_mx[23:0] * dt_mag;
  assign lo_y   = spd_my[23:0] * dt_mag;

  assign sh_x = pp_x_q >> SH;
  assign sh_y = pp_y_q >> SH;
  assign r_x  = (|sh_x[80:41] || sh_x[40:0] > CAP) ? CAP : sh_x[40:0];
  assign r_y  = (|sh_y[80:41] || sh_y[40:0] > CAP) ? CAP : sh_y[40:0];
  assign off_x = (spd_x_q[47] ^ dt_q[32]) ? -$signed({23'd0, r_x}) : $signed({23'd0, r_x});
  assign off_y = (spd_y_q[47] ^ dt_q[32]) ? -$signed({23'd0, r_y}) : $signed({23'd0, r_y});
  assign ex_d = sat_pos($signed({{32{trk_x_q[31]}}, trk_x_q}) + off_x);
  assign ey_d = sat_pos($signed({{32{trk_y_q[31]}}, trk_y_q}) + off_y);

  assign mx   = (cmd_q == abt_pkg::CMD_MEAS) ? 33'(in_x_q) : 33'(ex_d);
  assign my   = (cmd_q == abt_pkg::CMD_MEAS) ? 33'(in_y_q) : 33'(ey_d);
  assign rx_d = mx - 33'(ex_d);
  assign ry_d = my - 33'(ey_d);

  assign rx_mag = rx_q[32] ? 33'(-rx_q) : 33'(rx_q);
  assign ry_mag = ry_q[32] ? 33'(-ry_q) : 33'(ry_q);
  assign ad_x   = 64'(pa_x_q >> FRAC_BITS);
  assign ad_y   = 64'(pa_y_q >> FRAC_BITS);
  assign ox_d = sat_pos($signed({{32{ex_q[31]}}, ex_q})
                        + (rx_q[32] ? -$signed(ad_x) : $signed(ad_x)));
  assign oy_d = sat_pos($signed({{32{ey_q[31]}}, ey_q})
                        + (ry_q[32] ? -$signed(ad_y) : $signed(ad_y)));

  assign dx_x  = 33'(in_x_q) - 33'(first_x_q);
  assign dx_y  = 33'(in_y_q) - 33'(first_y_q);
  assign dx_mx = dx_x[32] ? 33'(-dx_x) : 33'(dx_x);
  assign dx_my = dx_y[32] ? 33'(-dx_y) : 33'(dx_y);

  assign n17      = (step_q == 16'd0) ? 17'd1 : {1'b0, step_q};
  assign n18      = {1'b0, n17} + 18'd1;
  assign den_full = n17 * n18;
  assign den      = den_full[32:0];
  assign a_coef   = {n17, 2'b00} - 19'd2;

  always_comb begin
    div_num = '0;
    div_dsr = dt_mag;
    case (ctl_i.div_sel)
      abt_pkg::DS_VX: div_num = is_init ? (DVW'(dx_mx) << FRAC_BITS) : pb_x_q;
      abt_pkg::DS_VY: div_num = is_init ? (DVW'(dx_my) << FRAC_BITS) : pb_y_q;
      abt_pkg::DS_GA: begin
        div_num = (DVW'(a_coef) << FRAC_BITS) + DVW'(den[32:1]);
        div_dsr = den;
      end
      abt_pkg::DS_GB: begin
        div_num = (DVW'(3'd6) << FRAC_BITS) + DVW'(den[32:1]);
        div_dsr = den;
      end
      default: div_num = '0;
    endcase
  end

  abt_div #(
    .DVW(DVW),
    .DSW(DSW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (ctl_i.div_start),
    .dividend_i(div_num),
    .divisor_i (div_dsr),
    .quotient_o(quo),
    .done_o    (div_done)
  );

  assign q64     = 64'(quo);
  assign neg_vx  = (is_init ? dx_x[32] : rx_q[32]) ^ dt_q[32];
  assign neg_vy  = (is_init ? dx_y[32] : ry_q[32]) ^ dt_q[32];
  assign base_vx = is_init ? 64'sd0 : $signed({{16{spd_x_q[47]}}, spd_x_q});
  assign base_vy = is_init ? 64'sd0 : $signed({{16{spd_y_q[47]}}, spd_y_q});
  assign spd_x_d = sat_vel(base_vx + (neg_vx ? -$signed(q64) : $signed(q64)));
  assign spd_y_d = sat_vel(base_vy + (neg_vy ? -$signed(q64) : $signed(q64)));

  always_comb begin
    res_x_d  = in_x_q;
    res_y_d  = in_y_q;
    res_t_d  = in_t_q;
    res_st_d = abt_pkg::ST_NO_INIT;
    if (is_init) begin
      if (fin_q) begin
        res_st_d = (dt_q == 33'sd0) ? abt_pkg::ST_ZERO_DT : abt_pkg::ST_OK;
      end
    end else if (!rdy_q) begin
      res_x_d = '0;
      res_y_d = '0;
      res_t_d = '0;
    end else if (cmd_q == abt_pkg::CMD_PRED) begin
      res_x_d  = ex_q;
      res_y_d  = ey_q;
      res_st_d = abt_pkg::ST_OK;
    end else begin
      res_x_d  = ox_q;
      res_y_d  = oy_q;
      res_st_d = (dt_q == 33'sd0) ? abt_pkg::ST_ZERO_DT : abt_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= '0;
      rdy_q   <= 1'b0;
      spd_x_q <= '0;
      spd_y_q <= '0;
      max_q   <= abt_pkg::MAX_STEPS_RST;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (ctl_i.decode && is_init) begin
        pc_q <= fin_q ? 16'd0 : pc_d;
      end
      if (ctl_i.div_take && ctl_i.div_sel == abt_pkg::DS_VX) begin
        spd_x_q <= spd_x_d;
      end
      if (ctl_i.div_take && ctl_i.div_sel == abt_pkg::DS_VY) begin
        spd_y_q <= spd_y_d;
      end
      if (ctl_i.finish && is_init && fin_q) begin
        rdy_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      cmd_q  <= command_i;
      in_x_q <= coord_x_i;
      in_y_q <= coord_y_i;
      in_t_q <= stamp_i;
      fin_q  <= final_point_i;
    end
    if (ctl_i.decode) begin
      dt_q <= dt_d;
      if (is_init && pc_q == 16'd0) begin
        first_x_q <= in_x_q;
        first_y_q <= in_y_q;
        first_t_q <= in_t_q;
      end
      if (is_init && fin_q) begin
        step_q <= pc_d;
      end
    end
    if (ctl_i.mul1) begin
      ph_x_q <= spd_mx[47:24] * dt_mag;
      ph_y_q <= spd_my[47:24] * dt_mag;
    end
    if (ctl_i.mul2) begin
      pp_x_q <= {ph_x_q, 24'd0} + {24'd0, lo_x};
      pp_y_q <= {ph_y_q, 24'd0} + {24'd0, lo_y};
    end
    if (ctl_i.extrap) begin
      ex_q <= ex_d;
      ey_q <= ey_d;
      rx_q <= rx_d;
      ry_q <= ry_d;
    end
    if (ctl_i.step_inc) begin
      step_q <= step_q + 16'd1;
    end
    if (ctl_i.blend1) begin
      pa_x_q <= alpha_q * rx_mag;
      pa_y_q <= alpha_q * ry_mag;
      pb_x_q <= beta_q * rx_mag;
      pb_y_q <= beta_q * ry_mag;
    end
    if (ctl_i.blend2) begin
      ox_q <= ox_d;
      oy_q <= oy_d;
    end
    if (ctl_i.div_take && ctl_i.div_sel == abt_pkg::DS_GA) begin
      alpha_q <= quo[GW-1:0];
    end
    if (ctl_i.div_take && ctl_i.div_sel == abt_pkg::DS_GB) begin
      beta_q <= quo[GW-1:0];
    end
    if (ctl_i.finish) begin
      res_x_q  <= res_x_d;
      res_y_q  <= res_y_d;
      res_t_q  <= res_t_d;
      res_st_q <= res_st_d;
      res_vx_q <= (!is_init && !rdy_q) ? 48'sd0 : spd_x_q;
      res_vy_q <= (!is_init && !rdy_q) ? 48'sd0 : spd_y_q;
      if (is_init && fin_q) begin
        trk_x_q <= in_x_q;
        trk_y_q <= in_y_q;
        trk_t_q <= in_t_q;
      end else if (!is_init && rdy_q && cmd_q != abt_pkg::CMD_PRED) begin
        trk_x_q <= ox_q;
        trk_y_q <= oy_q;
        trk_t_q <= in_t_q;
      end
    end
  end

  assign sts_o.cmd      = cmd_q;
  assign sts_o.fin      = fin_q;
  assign sts_o.rdy      = rdy_q;
  assign sts_o.dt_zero  = (dt_q == 33'sd0);
  assign sts_o.step_lt  = (step_q < max_q);
  assign sts_o.div_done = div_done;

  assign pos_x_o    = res_x_q;
  assign pos_y_o    = res_y_q;
  assign pos_time_o = res_t_q;
  assign vel_x_o    = res_vx_q;
  assign vel_y_o    = res_vy_q;
  assign status_o   = res_st_q;

endmodule

/* design/abt_ctrl.sv */
// Controller state machine sequencing the tracker datapath for one transaction at a time.
module abt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  abt_pkg::sts_t sts_i,
  output abt_pkg::ctl_t ctl_o
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'h0001,
    S_DEC   = 13'h0002,
    S_ROUTE = 13'h0004,
    S_MUL1  = 13'h0008,
    S_MUL2  = 13'h0010,
    S_EXT   = 13'h0020,
    S_VX    = 13'h0040,
    S_VY    = 13'h0080,
    S_GA    = 13'h0100,
    S_GB    = 13'h0200,
    S_BL1   = 13'h0400,
    S_BL2   = 13'h0800,
    S_OUT   = 13'h1000
  } state_e;

  state_e state_q, state_d;
  logic   div_run_q, div_run_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    logic   is_div;
    state_e nxt;
    is_div      = 1'b0;
    nxt         = S_IDLE;
    state_d     = state_q;
    div_run_d   = div_run_q;
    out_valid_d = out_valid_q;
    ctl_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.latch = 1'b1;
          state_d     = S_DEC;
        end
      end
      S_DEC: begin
        ctl_o.decode = 1'b1;
        state_d      = S_ROUTE;
      end
      S_ROUTE: begin
        if (sts_i.cmd == abt_pkg::CMD_INIT) begin
          if (!sts_i.fin) begin
            state_d = S_OUT;
          end else if (sts_i.dt_zero) begin
            state_d = S_GA;
          end else begin
            state_d = S_VX;
          end
        end else if (!sts_i.rdy) begin
          state_d = S_OUT;
        end else begin
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        ctl_o.mul1 = 1'b1;
        state_d    = S_MUL2;
      end
      S_MUL2: begin
        ctl_o.mul2 = 1'b1;
        state_d    = S_EXT;
      end
      S_EXT: begin
        ctl_o.extrap = 1'b1;
        if (sts_i.cmd == abt_pkg::CMD_PRED) begin
          state_d = S_OUT;
        end else if (sts_i.step_lt) begin
          ctl_o.step_inc = 1'b1;
          state_d        = S_GA;
        end else begin
          state_d = S_BL1;
        end
      end
      S_VX: begin
        is_div        = 1'b1;
        ctl_o.div_sel = abt_pkg::DS_VX;
        nxt           = S_VY;
      end
      S_VY: begin
        is_div        = 1'b1;
        ctl_o.div_sel = abt_pkg::DS_VY;
        nxt           = (sts_i.cmd == abt_pkg::CMD_INIT) ? S_GA : S_OUT;
      end
      S_GA: begin
        is_div        = 1'b1;
        ctl_o.div_sel = abt_pkg::DS_GA;
        nxt           = S_GB;
      end
      S_GB: begin
        is_div        = 1'b1;
        ctl_o.div_sel = abt_pkg::DS_GB;
        nxt           = (sts_i.cmd == abt_pkg::CMD_INIT) ? S_OUT : S_BL1;
      end
      S_BL1: begin
        ctl_o.blend1 = 1'b1;
        state_d      = S_BL2;
      end
      S_BL2: begin
        ctl_o.blend2 = 1'b1;
        state_d      = sts_i.dt_zero ? S_OUT : S_VX;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          ctl_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (is_div) begin
      if (!div_run_q) begin
        ctl_o.div_start = 1'b1;
        div_run_d       = 1'b1;
      end else if (sts_i.div_done) begin
        ctl_o.div_take = 1'b1;
        div_run_d      = 1'b0;
        state_d        = nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_run_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_run_q   <= div_run_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
